// ===== hw/rtl/playback_state_resolver_core_assert.svh =====
// Assertion macros used by the checker file.
`ifndef PLAYBACK_STATE_RESOLVER_CORE_ASSERT_SVH
`define PLAYBACK_STATE_RESOLVER_CORE_ASSERT_SVH

// Clocked assertion, switched off while reset is held.
`define PSR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define PSR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/psr_pkg.sv =====
`timescale 1ns / 1ps

package psr_pkg;

  // Player state codes
  localparam logic [3:0] ST_OPENING  = 4'd0;
  localparam logic [3:0] ST_PREFILL  = 4'd1;
  localparam logic [3:0] ST_PRIMING  = 4'd2;
  localparam logic [3:0] ST_PLAYING  = 4'd3;
  localparam logic [3:0] ST_PAUSED   = 4'd4;
  localparam logic [3:0] ST_SEEKING  = 4'd5;
  localparam logic [3:0] ST_DRAINING = 4'd6;
  localparam logic [3:0] ST_ENDED    = 4'd7;
  localparam logic [3:0] ST_ERROR    = 4'd8;

  // Sample rate used when the word carries zero
  localparam logic [19:0] DEFAULT_RATE = 20'd48000;

  // Upper bound on rule applications per word
  localparam int ITER_LIMIT = 16;

  // Conditions the rule step looks at, settled before iterating
  typedef struct packed {
    logic init_done;
    logic init_ok;
    logic a_paused;
    logic seek_failed;
    logic seek_idle;
    logic serial_match;
    logic prefill_ready;
    logic at_end;
    logic demux_end;
    logic q_empty;
  } psr_flags_t;

endpackage

// ===== hw/rtl/psr_cmp_unit.sv =====
`timescale 1ns / 1ps

// Shared 32-bit magnitude / equality comparator.
module psr_cmp_unit (
  input  logic [31:0] cmp_a,
  input  logic [31:0] cmp_b,
  output logic        cmp_ge,
  output logic        cmp_eq
);

  assign cmp_ge = (cmp_a >= cmp_b);
  assign cmp_eq = (cmp_a == cmp_b);

endmodule

// ===== hw/rtl/psr_rules.sv =====
`timescale 1ns / 1ps

// One application of the transition rules; first match wins.
module psr_rules (
  input  logic [3:0]          cur_state,
  input  psr_pkg::psr_flags_t flags,
  output logic [3:0]          next_state
);

  logic active;

  assign active = (cur_state == psr_pkg::ST_PLAYING)  || (cur_state == psr_pkg::ST_PREFILL) ||
                  (cur_state == psr_pkg::ST_DRAINING) || (cur_state == psr_pkg::ST_PRIMING);

  always_comb begin
    next_state = cur_state;
    if (cur_state == psr_pkg::ST_OPENING && flags.init_done) begin
      if (!flags.init_ok) next_state = psr_pkg::ST_ERROR;
      else if (flags.a_paused) next_state = psr_pkg::ST_PAUSED;
      else next_state = psr_pkg::ST_PREFILL;
    end else if (cur_state == psr_pkg::ST_SEEKING && flags.seek_idle) begin
      // paused seek still waiting on its frame holds in seeking
      if (!flags.seek_failed && flags.a_paused && !flags.serial_match)
        next_state = psr_pkg::ST_SEEKING;
      else if (flags.a_paused) next_state = psr_pkg::ST_PAUSED;
      else next_state = psr_pkg::ST_PREFILL;
    end else if (active && flags.a_paused) begin
      next_state = psr_pkg::ST_PAUSED;
    end else if (cur_state == psr_pkg::ST_PAUSED && !flags.a_paused) begin
      next_state = flags.serial_match ? psr_pkg::ST_PLAYING : psr_pkg::ST_PREFILL;
    end else if (cur_state == psr_pkg::ST_PREFILL && !flags.a_paused && flags.prefill_ready) begin
      next_state = psr_pkg::ST_PRIMING;
    end else if (active) begin
      if (flags.at_end)
        next_state = psr_pkg::ST_ENDED;
      else if (flags.demux_end && cur_state == psr_pkg::ST_PLAYING && flags.q_empty)
        next_state = psr_pkg::ST_DRAINING;
    end
  end

endmodule

// ===== hw/rtl/playback_state_resolver_core.sv =====
`timescale 1ns / 1ps

// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_ready  | state, flags, serials, depth, audio, rate
// out_    | output    | out_valid/out_ready| steady_state, state_changed
// cfg_    | input     | cfg_wr_en          | video prefill target, 16 bit
//
// A word takes three compare phases on the shared comparator, then rule
// applications in PH_ITER until the fixed point is seen, then the output load
// in PH_FINISH (at most 3 transitions per word); busy throughout.
// rst_n is synchronous, active low; it clears the sequencer and out_valid and
// sets the prefill target to 3. A held result does not block the next word
// from entering; only the final load waits for the output register.
module playback_state_resolver_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_current_state,
  input  logic [3:0]  in_control_flags,
  input  logic [2:0]  in_video_flags,
  input  logic [3:0]  in_audio_flags,
  input  logic [31:0] in_seek_pending_serial,
  input  logic [31:0] in_shown_serial,
  input  logic [31:0] in_active_serial,
  input  logic [15:0] in_video_depth,
  input  logic [23:0] in_audio_buffered,
  input  logic [19:0] in_sample_rate,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_steady_state,
  output logic        out_state_changed
);

  localparam int ITER_W = $clog2(psr_pkg::ITER_LIMIT);

  // Sequencer phases
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_CMP_VID = 3'd1;
  localparam logic [2:0] PH_CMP_AUD = 3'd2;
  localparam logic [2:0] PH_CMP_SER = 3'd3;
  localparam logic [2:0] PH_ITER    = 3'd4;
  localparam logic [2:0] PH_FINISH  = 3'd5;

  logic [2:0]        phase_r, phase_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic [3:0]        state_r, state_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [15:0]       target_r;

  // latched word
  logic [3:0]  start_r;
  logic [3:0]  ctl_r;
  logic [2:0]  vid_r;
  logic [3:0]  aud_r;
  logic        seek_idle_r;
  logic [31:0] shown_r;
  logic [31:0] active_r;
  logic [15:0] depth_r;
  logic [23:0] abuf_r;
  logic [19:0] rate_r;

  // compare results
  logic depth_ge_r, abuf_ge_r, ser_eq_r;

  logic [3:0] out_state_r;
  logic       out_changed_r;

  logic        accept;
  logic [31:0] cmp_a, cmp_b;
  logic        cmp_ge, cmp_eq;
  logic [19:0] eff_rate;
  logic [25:0] abuf_x3p2;
  psr_pkg::psr_flags_t flags;
  logic [3:0]  rule_next;
  logic        iter_done;
  logic        out_free;

  assign accept   = in_valid && in_ready;
  assign in_ready = (phase_r == PH_IDLE);
  assign out_free = !out_valid_r || out_ready;

  // abuf >= floor(rate/3)  <=>  3*abuf + 2 >= rate
  assign eff_rate  = (rate_r != 20'd0) ? rate_r : psr_pkg::DEFAULT_RATE;
  assign abuf_x3p2 = (26'(abuf_r) << 1) + 26'(abuf_r) + 26'd2;

  // operand select for the shared comparator
  always_comb begin
    case (phase_r)
      PH_CMP_VID: begin
        cmp_a = 32'(depth_r);
        cmp_b = 32'(target_r);
      end
      PH_CMP_AUD: begin
        cmp_a = 32'(abuf_x3p2);
        cmp_b = 32'(eff_rate);
      end
      PH_CMP_SER: begin
        cmp_a = shown_r;
        cmp_b = active_r;
      end
      default: begin
        cmp_a = shown_r;
        cmp_b = active_r;
      end
    endcase
  end

  psr_cmp_unit u_cmp (
    .cmp_a  (cmp_a),
    .cmp_b  (cmp_b),
    .cmp_ge (cmp_ge),
    .cmp_eq (cmp_eq)
  );

  // condition bundle for the rule step
  always_comb begin
    flags.init_done     = ctl_r[0];
    flags.init_ok       = ctl_r[1];
    flags.a_paused      = ctl_r[2];
    flags.seek_failed   = ctl_r[3];
    flags.seek_idle     = seek_idle_r;
    flags.serial_match  = ser_eq_r;
    flags.prefill_ready = (depth_ge_r || vid_r[0]) &&
                          (!aud_r[1] || aud_r[2] || (abuf_ge_r && aud_r[0]));
    flags.at_end        = vid_r[0] && vid_r[1] && (!aud_r[1] || aud_r[3]);
    flags.demux_end     = vid_r[2];
    flags.q_empty       = vid_r[1];
  end

  psr_rules u_rules (
    .cur_state  (state_r),
    .flags      (flags),
    .next_state (rule_next)
  );

  assign iter_done = (rule_next == state_r) ||
                     (iter_r == ITER_W'(psr_pkg::ITER_LIMIT - 1));

  // sequencer
  always_comb begin
    phase_nxt     = phase_r;
    iter_nxt      = iter_r;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    case (phase_r)
      PH_IDLE: begin
        if (accept) begin
          phase_nxt = PH_CMP_VID;
          state_nxt = in_current_state;
          iter_nxt  = '0;
        end
      end
      PH_CMP_VID: phase_nxt = PH_CMP_AUD;
      PH_CMP_AUD: phase_nxt = PH_CMP_SER;
      PH_CMP_SER: phase_nxt = PH_ITER;
      PH_ITER: begin
        state_nxt = rule_next;
        iter_nxt  = iter_r + ITER_W'(1);
        if (iter_done) phase_nxt = PH_FINISH;
      end
      PH_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          phase_nxt     = PH_IDLE;
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      out_valid_r <= 1'b0;
      target_r    <= 16'd3;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) target_r <= cfg_wr_data;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    iter_r  <= iter_nxt;
    state_r <= state_nxt;
    if (accept) begin
      start_r     <= in_current_state;
      ctl_r       <= in_control_flags;
      vid_r       <= in_video_flags;
      aud_r       <= in_audio_flags;
      seek_idle_r <= (in_seek_pending_serial == 32'd0);
      shown_r     <= in_shown_serial;
      active_r    <= in_active_serial;
      depth_r     <= in_video_depth;
      abuf_r      <= in_audio_buffered;
      rate_r      <= in_sample_rate;
    end
    if (phase_r == PH_CMP_VID) depth_ge_r <= cmp_ge;
    if (phase_r == PH_CMP_AUD) abuf_ge_r  <= cmp_ge;
    if (phase_r == PH_CMP_SER) ser_eq_r   <= cmp_eq;
    if (phase_r == PH_FINISH && out_free) begin
      out_state_r   <= state_r;
      out_changed_r <= (state_r != start_r);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_steady_state  = out_state_r;
  assign out_state_changed = out_changed_r;

endmodule

// ===== hw/rtl/psr_checker.sv =====
`timescale 1ns / 1ps
`include "playback_state_resolver_core_assert.svh"

// Port-level checks on the resolver.
module psr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] out_steady_state,
  input logic       out_state_changed
);

  // a taken word keeps the block busy for at least the next cycle
  `PSR_ASSERT(a_busy_after_accept, clk, rst_n, (in_valid && in_ready) |=> !in_ready, "ready after accept")

  // a result only appears after a busy cycle
  `PSR_ASSERT(a_result_after_work, clk, rst_n, $rose(out_valid) |-> !$past(in_ready), "result from idle")

  // a stalled result holds
  `PSR_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_steady_state) && $stable(out_state_changed)), "stalled result moved")

  // reset empties the output register
  `PSR_ASSERT_ALWAYS(a_reset_clear, clk, !rst_n |=> !out_valid, "out_valid after reset")

endmodule

bind playback_state_resolver_core psr_checker u_psr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_steady_state  (out_steady_state),
  .out_state_changed (out_state_changed)
);

// ===== tb/tb_playback_state_resolver_core.sv =====
`timescale 1ns / 1ps

module tb_playback_state_resolver_core;

  // Flag bit masks within the status word
  localparam logic [3:0] CTL_INIT_DONE = 4'b0001;
  localparam logic [3:0] CTL_INIT_OK   = 4'b0010;
  localparam logic [3:0] CTL_A_PAUSED  = 4'b0100;
  localparam logic [3:0] CTL_SEEK_FAIL = 4'b1000;
  localparam logic [2:0] VID_DEC_END   = 3'b001;
  localparam logic [2:0] VID_Q_EMPTY   = 3'b010;
  localparam logic [2:0] VID_DEMUX_END = 3'b100;
  localparam logic [3:0] AUD_SYNC      = 4'b0001;
  localparam logic [3:0] AUD_STARTED   = 4'b0010;
  localparam logic [3:0] AUD_DEC_END   = 4'b0100;
  localparam logic [3:0] AUD_FINISHED  = 4'b1000;

  // State codes with no rule attached
  localparam logic [3:0] ST_UNNAMED_LO = 4'd9;
  localparam logic [3:0] ST_UNNAMED_HI = 4'd15;

  localparam logic [19:0] RATE_DIVISOR = 20'd3;
  localparam logic [15:0] TARGET_RESET = 16'd3;
  localparam logic [19:0] RATE_MAX     = 20'hFFFFF;

  // Receiver stall modes
  localparam int RX_OPEN   = 0;
  localparam int RX_COIN   = 1;
  localparam int RX_BURSTY = 2;

  localparam int TAIL_CYCLES = 12;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [3:0]  cur_state;
    logic [3:0]  ctl;
    logic [2:0]  vid;
    logic [3:0]  aud;
    logic [31:0] seek_serial;
    logic [31:0] shown_serial;
    logic [31:0] active_serial;
    logic [15:0] depth;
    logic [23:0] abuf;
    logic [19:0] rate;
  } status_word_t;

  typedef struct packed {
    logic [3:0] from_state;
    logic [3:0] steady;
    logic       changed;
  } resolve_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = 16'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [3:0]  in_current_state = 4'd0;
  logic [3:0]  in_control_flags = 4'd0;
  logic [2:0]  in_video_flags = 3'd0;
  logic [3:0]  in_audio_flags = 4'd0;
  logic [31:0] in_seek_pending_serial = 32'd0;
  logic [31:0] in_shown_serial = 32'd0;
  logic [31:0] in_active_serial = 32'd0;
  logic [15:0] in_video_depth = 16'd0;
  logic [23:0] in_audio_buffered = 24'd0;
  logic [19:0] in_sample_rate = 20'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_steady_state;
  logic        out_state_changed;

  // Shared testbench state
  resolve_result_t expected_states[$];
  logic [15:0]     prefill_target = TARGET_RESET;
  int              mismatches = 0;
  int              cycles = 0;
  bit              valid_high = 1'b0;
  int              burst_left = 0;

  playback_state_resolver_core dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_wr_en              (cfg_wr_en),
    .cfg_wr_data            (cfg_wr_data),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_current_state       (in_current_state),
    .in_control_flags       (in_control_flags),
    .in_video_flags         (in_video_flags),
    .in_audio_flags         (in_audio_flags),
    .in_seek_pending_serial (in_seek_pending_serial),
    .in_shown_serial        (in_shown_serial),
    .in_active_serial       (in_active_serial),
    .in_video_depth         (in_video_depth),
    .in_audio_buffered      (in_audio_buffered),
    .in_sample_rate         (in_sample_rate),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_steady_state       (out_steady_state),
    .out_state_changed      (out_state_changed)
  );

  always #1 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic bit is_active_state(logic [3:0] s);
    return s == psr_pkg::ST_PLAYING || s == psr_pkg::ST_PREFILL ||
           s == psr_pkg::ST_DRAINING || s == psr_pkg::ST_PRIMING;
  endfunction

  // Apply the transition rules until the state settles
  function automatic resolve_result_t resolve_playback(status_word_t w, logic [15:0] target);
    logic [19:0]     rate_hz;
    logic [19:0]     audio_goal;
    bit              init_done, init_ok, a_paused, seek_failed;
    bit              dec_end, q_empty, demux_end;
    bit              sync_ready, a_started, a_dec_end, a_finished;
    bit              same_serial, prefill_ready, audio_active, at_end;
    logic [3:0]      s;
    logic [3:0]      nxt;
    resolve_result_t r;
    int              i;
    init_done   = (w.ctl & CTL_INIT_DONE) != 0;
    init_ok     = (w.ctl & CTL_INIT_OK) != 0;
    a_paused    = (w.ctl & CTL_A_PAUSED) != 0;
    seek_failed = (w.ctl & CTL_SEEK_FAIL) != 0;
    dec_end     = (w.vid & VID_DEC_END) != 0;
    q_empty     = (w.vid & VID_Q_EMPTY) != 0;
    demux_end   = (w.vid & VID_DEMUX_END) != 0;
    sync_ready  = (w.aud & AUD_SYNC) != 0;
    a_started   = (w.aud & AUD_STARTED) != 0;
    a_dec_end   = (w.aud & AUD_DEC_END) != 0;
    a_finished  = (w.aud & AUD_FINISHED) != 0;
    same_serial = w.shown_serial == w.active_serial;
    rate_hz     = (w.rate != 0) ? w.rate : psr_pkg::DEFAULT_RATE;
    audio_goal  = rate_hz / RATE_DIVISOR;
    prefill_ready = ((w.depth >= target) || dec_end) &&
                    (!a_started || a_dec_end || ((w.abuf >= {4'd0, audio_goal}) && sync_ready));
    audio_active = a_started && !a_finished;
    at_end       = dec_end && q_empty && (!audio_active || a_finished);
    s = w.cur_state;
    for (i = 0; i < psr_pkg::ITER_LIMIT; i++) begin
      nxt = s;
      if (s == psr_pkg::ST_OPENING && init_done) begin
        nxt = !init_ok ? psr_pkg::ST_ERROR :
              (a_paused ? psr_pkg::ST_PAUSED : psr_pkg::ST_PREFILL);
      end else if (s == psr_pkg::ST_SEEKING && w.seek_serial == 0) begin
        // a clean seek still waiting on the right frame holds in seeking
        if (!seek_failed && a_paused && !same_serial) nxt = psr_pkg::ST_SEEKING;
        else nxt = a_paused ? psr_pkg::ST_PAUSED : psr_pkg::ST_PREFILL;
      end else if (is_active_state(s) && a_paused) begin
        nxt = psr_pkg::ST_PAUSED;
      end else if (s == psr_pkg::ST_PAUSED && !a_paused) begin
        nxt = same_serial ? psr_pkg::ST_PLAYING : psr_pkg::ST_PREFILL;
      end else if (s == psr_pkg::ST_PREFILL && !a_paused && prefill_ready) begin
        nxt = psr_pkg::ST_PRIMING;
      end else if (is_active_state(s)) begin
        if (at_end) nxt = psr_pkg::ST_ENDED;
        else if (demux_end && s == psr_pkg::ST_PLAYING && q_empty)
          nxt = psr_pkg::ST_DRAINING;
      end
      if (nxt == s) break;
      s = nxt;
    end
    r.from_state = w.cur_state;
    r.steady     = s;
    r.changed    = s != w.cur_state;
    return r;
  endfunction

  function automatic status_word_t mk_status(logic [3:0] st, logic [3:0] ctl, logic [2:0] vid,
                                             logic [3:0] aud, logic [31:0] seek,
                                             logic [31:0] shown, logic [31:0] active,
                                             logic [15:0] depth, logic [23:0] abuf,
                                             logic [19:0] rate);
    status_word_t w;
    w.cur_state     = st;
    w.ctl           = ctl;
    w.vid           = vid;
    w.aud           = aud;
    w.seek_serial   = seek;
    w.shown_serial  = shown;
    w.active_serial = active;
    w.depth         = depth;
    w.abuf          = abuf;
    w.rate          = rate;
    return w;
  endfunction

  // Random status word, weighted toward the rule boundaries
  function automatic status_word_t random_status();
    status_word_t w;
    int           d;
    int           goal;
    if ($urandom_range(0, 9) == 0)
      w.cur_state = 4'($urandom_range(ST_UNNAMED_LO, ST_UNNAMED_HI));
    else
      w.cur_state = 4'($urandom_range(psr_pkg::ST_OPENING, psr_pkg::ST_ERROR));
    w.ctl = 4'($urandom);
    w.vid = 3'($urandom);
    w.aud = 4'($urandom);
    w.seek_serial   = ($urandom_range(0, 1) == 0) ? 32'd0 : $urandom;
    w.active_serial = $urandom;
    w.shown_serial  = ($urandom_range(0, 1) == 0) ? w.active_serial : $urandom;
    case ($urandom_range(0, 3))
      0: begin
        d = int'(prefill_target) + int'($urandom_range(0, 4)) - 2;
        if (d < 0) d = 0;
        if (d > 65535) d = 65535;
        w.depth = 16'(d);
      end
      1: w.depth = 16'($urandom);
      2: w.depth = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'hFFFF;
      default: w.depth = 16'($urandom_range(0, 8));
    endcase
    case ($urandom_range(0, 5))
      0: w.rate = 20'd0;
      1: w.rate = RATE_MAX;
      2: w.rate = 20'd44100;
      3: w.rate = 20'd8000;
      default: w.rate = 20'($urandom);
    endcase
    goal = int'(((w.rate != 0) ? w.rate : psr_pkg::DEFAULT_RATE) / RATE_DIVISOR);
    case ($urandom_range(0, 3))
      0, 1: w.abuf = 24'(goal + int'($urandom_range(0, 4)) - 2);
      2: w.abuf = 24'($urandom);
      default: w.abuf = ($urandom_range(0, 1) == 0) ? 24'd0 : 24'hFFFFFF;
    endcase
    return w;
  endfunction

  // Bursts of words with random gaps in between
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        valid_high = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Drive one word and hold it until accepted
  task automatic send_status(status_word_t w);
    in_current_state       <= w.cur_state;
    in_control_flags       <= w.ctl;
    in_video_flags         <= w.vid;
    in_audio_flags         <= w.aud;
    in_seek_pending_serial <= w.seek_serial;
    in_shown_serial        <= w.shown_serial;
    in_active_serial       <= w.active_serial;
    in_video_depth         <= w.depth;
    in_audio_buffered      <= w.abuf;
    in_sample_rate         <= w.rate;
    in_valid               <= 1'b1;
    valid_high = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_states.push_back(resolve_playback(w, prefill_target));
    pace_sender();
  endtask

  // Stop sending and wait until every result is back
  task automatic settle_block();
    if (valid_high) begin
      in_valid <= 1'b0;
      valid_high = 1'b0;
    end
    while (expected_states.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic set_prefill_target(logic [15:0] v);
    settle_block();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    prefill_target = v;
  endtask

  task automatic send_random_words(int count);
    int n;
    for (n = 0; n < count; n++) send_status(random_status());
  endtask

  // Receiver: ready pattern changes mode every so often
  int rx_mode = RX_OPEN;
  int rx_left = 0;
  int stall_left = 0;
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(RX_OPEN, RX_BURSTY);
      rx_left = $urandom_range(20, 200);
    end
    rx_left--;
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN: out_ready <= 1'b1;
        RX_COIN: out_ready <= 1'($urandom_range(0, 1));
        default: begin
          if ($urandom_range(0, 15) == 0) begin
            stall_left = $urandom_range(3, 16);
            out_ready <= 1'b0;
          end else begin
            out_ready <= 1'b1;
          end
        end
      endcase
    end
  end

  // Result checker
  resolve_result_t want;
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_states.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: steady %0d changed %0b",
                   out_steady_state, out_state_changed);
        mismatches++;
      end else begin
        want = expected_states.pop_front();
        if (out_steady_state !== want.steady || out_state_changed !== want.changed) begin
          if (mismatches < 10)
            $display("mismatch from state %0d: expected steady %0d changed %0b, got %0d %0b",
                     want.from_state, want.steady, want.changed,
                     out_steady_state, out_state_changed);
          mismatches++;
        end
      end
    end
  end

  // One word per rule and per boundary, at the reset target of 3
  task automatic test_directed_cases();
    // opening: not done, done ok, done ok while paused, init failed
    send_status(mk_status(psr_pkg::ST_OPENING, 4'd0, 3'd0, 4'd0, 0, 0, 0, 0, 0, 0));
    send_status(mk_status(psr_pkg::ST_OPENING, CTL_INIT_DONE | CTL_INIT_OK, 3'd0, 4'd0,
                          0, 1, 1, 16'd0, 0, 0));
    send_status(mk_status(psr_pkg::ST_OPENING, CTL_INIT_DONE | CTL_INIT_OK | CTL_A_PAUSED,
                          3'd0, 4'd0, 0, 1, 1, 0, 0, 0));
    send_status(mk_status(psr_pkg::ST_OPENING, CTL_INIT_DONE, 3'd0, 4'd0, 0, 0, 0, 0, 0, 0));
    // seeking: in flight, held on serial mismatch, failed seek, resumed
    send_status(mk_status(psr_pkg::ST_SEEKING, 4'd0, 3'd0, 4'd0, 32'hFFFFFFFF,
                          0, 0, 0, 0, 0));
    send_status(mk_status(psr_pkg::ST_SEEKING, CTL_A_PAUSED, 3'd0, 4'd0, 0, 5, 6, 0, 0, 0));
    send_status(mk_status(psr_pkg::ST_SEEKING, CTL_A_PAUSED | CTL_SEEK_FAIL, 3'd0, 4'd0,
                          0, 5, 6, 0, 0, 0));
    send_status(mk_status(psr_pkg::ST_SEEKING, 4'd0, 3'd0, 4'd0, 0, 7, 7, 16'd3, 0, 0));
    // pause and resume
    send_status(mk_status(psr_pkg::ST_PLAYING, CTL_A_PAUSED, 3'd0, 4'd0, 0, 0, 0, 0, 0, 0));
    send_status(mk_status(psr_pkg::ST_PAUSED, 4'd0, 3'd0, 4'd0, 0, 9, 9, 0, 0, 0));
    send_status(mk_status(psr_pkg::ST_PAUSED, 4'd0, 3'd0, 4'd0, 0, 9, 10, 0, 0, 0));
    // prefill around the video target
    send_status(mk_status(psr_pkg::ST_PREFILL, 4'd0, 3'd0, 4'd0, 0, 0, 0, 16'd3, 0, 0));
    send_status(mk_status(psr_pkg::ST_PREFILL, 4'd0, 3'd0, 4'd0, 0, 0, 0, 16'd2, 0, 0));
    send_status(mk_status(psr_pkg::ST_PREFILL, 4'd0, VID_DEC_END, 4'd0, 0, 0, 0, 16'd0, 0, 0));
    // audio threshold at the default rate and at the top rate
    send_status(mk_status(psr_pkg::ST_PREFILL, 4'd0, 3'd0, AUD_STARTED | AUD_SYNC, 0, 0, 0,
                          16'd3, 24'd16000, 20'd0));
    send_status(mk_status(psr_pkg::ST_PREFILL, 4'd0, 3'd0, AUD_STARTED | AUD_SYNC, 0, 0, 0,
                          16'd3, 24'd15999, 20'd0));
    send_status(mk_status(psr_pkg::ST_PREFILL, 4'd0, 3'd0, AUD_STARTED | AUD_SYNC, 0, 0, 0,
                          16'd3, 24'd349525, RATE_MAX));
    send_status(mk_status(psr_pkg::ST_PREFILL, 4'd0, 3'd0, AUD_STARTED | AUD_DEC_END, 0, 0, 0,
                          16'd3, 24'd0, 20'd44100));
    // end of stream and drain
    send_status(mk_status(psr_pkg::ST_PLAYING, 4'd0, VID_DEC_END | VID_Q_EMPTY,
                          AUD_STARTED | AUD_FINISHED, 0, 0, 0, 0, 0, 0));
    send_status(mk_status(psr_pkg::ST_PLAYING, 4'd0, VID_DEMUX_END | VID_Q_EMPTY, AUD_STARTED,
                          0, 0, 0, 0, 0, 0));
    // codes without rules pass through
    send_status(mk_status(ST_UNNAMED_LO, 4'hF, 3'h7, 4'hF, 0, 0, 0, 0, 0, 0));
    send_status(mk_status(ST_UNNAMED_HI, 4'd0, 3'd0, 4'd0, 0, 0, 0, 0, 0, 0));
    send_status(mk_status(psr_pkg::ST_ERROR, 4'hF, 3'h7, 4'hF, 0, 0, 0, 0, 0, 0));
    // all ones and all zeros
    send_status(mk_status(psr_pkg::ST_ENDED, 4'hF, 3'h7, 4'hF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                          32'hFFFFFFFF, 16'hFFFF, 24'hFFFFFF, RATE_MAX));
    send_status(mk_status(psr_pkg::ST_OPENING, 4'hF, 3'h7, 4'hF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                          32'hFFFFFFFF, 16'hFFFF, 24'hFFFFFF, RATE_MAX));
  endtask

  task automatic test_default_target();
    send_random_words(300);
  endtask

  task automatic test_target_zero();
    set_prefill_target(16'd0);
    send_random_words(200);
  endtask

  task automatic test_target_max();
    set_prefill_target(16'hFFFF);
    send_random_words(200);
  endtask

  task automatic test_target_sweep();
    set_prefill_target(16'($urandom_range(1, 8)));
    send_random_words(150);
    set_prefill_target(16'($urandom));
    send_random_words(150);
    set_prefill_target(16'($urandom_range(0, 255)));
    send_random_words(150);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_default_target();
    test_target_zero();
    test_target_max();
    test_target_sweep();
    settle_block();
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
